// ===== sv/spct_pkg.sv =====
// Shared widths, codes and stage payload types for the surface patch connection test.
package spct_pkg;

    localparam int CRD_W     = 16;              // centroid and normal fields
    localparam int D_W       = CRD_W + 1;       // centroid difference
    localparam int DN_W      = D_W + CRD_W;     // d * n product
    localparam int NN_W      = 2 * CRD_W;       // n * n product
    localparam int SQ_W      = 2 * D_W;         // d * d product, signed
    localparam int DD_W      = 32;              // d * d, never negative, below 2^32
    localparam int DOT_W     = DN_W + 2;        // sum of three d * n
    localparam int ABS_W     = DOT_W - 1;
    localparam int PERP_W    = ABS_W + 1;
    localparam int SIM_W     = NN_W + 2;        // sum of three n * n
    localparam int SABS_W    = SIM_W - 1;
    localparam int DDS_W     = DD_W + 2;        // |d|^2
    localparam int THR_W     = 16;
    localparam int ANG_W     = 15;
    localparam int ANG_SHIFT = 14;
    localparam int COEF_W    = 24;
    localparam int COEF2_W   = 2 * COEF_W;
    localparam int COEF_SCALE = 160;            // 40, and 4 to line Q.12 up with Q.14
    localparam int PL_W      = 17;              // low half of perp
    localparam int PH_W      = PERP_W - PL_W;   // high half of perp
    localparam int LHS_W     = 2 * PERP_W;
    localparam int CP_W      = 16;              // coef^2 is cut into three slices
    localparam int DL_W      = 17;              // |d|^2 low part
    localparam int DH_W      = DDS_W - DL_W;
    localparam int PART_W    = CP_W + DL_W;
    localparam int GRP_W     = PART_W + DL_W + 1;
    localparam int RHS_W     = GRP_W + 2 * CP_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_THR  = 2'd1;
    localparam logic [THR_W-1:0] DIST_THR_RESET = 16'd41;
    localparam logic [ANG_W-1:0] ANG_THR_RESET  = 15'd14746;

    typedef struct packed {
        logic [2:0][CRD_W-1:0] ca;
        logic [2:0][CRD_W-1:0] na;
        logic [2:0][CRD_W-1:0] cb;
        logic [2:0][CRD_W-1:0] nb;
    } pair_t;

    typedef struct packed {
        logic [2:0][D_W-1:0]   d;
        logic [2:0][CRD_W-1:0] na;
        logic [2:0][CRD_W-1:0] nb;
        logic [COEF_W-1:0]     coef;
    } diff_t;

    typedef struct packed {
        logic [2:0][DN_W-1:0] dna;
        logic [2:0][DN_W-1:0] dnb;
        logic [2:0][NN_W-1:0] nn;
        logic [2:0][DD_W-1:0] dd;
        logic [COEF2_W-1:0]   coef2;
    } prod_t;

    typedef struct packed {
        logic [DOT_W-1:0]   dot1;
        logic [DOT_W-1:0]   dot2;
        logic [SIM_W-1:0]   dotn;
        logic [DDS_W-1:0]   dds;
        logic [COEF2_W-1:0] coef2;
    } sums_t;

    typedef struct packed {
        logic [PERP_W-1:0]  perp;
        logic [DDS_W-1:0]   dds;
        logic [COEF2_W-1:0] coef2;
        logic               angle_ok;
    } geo_t;

endpackage

// ===== sv/spct_prod.sv =====
// Centroid difference and all element products, two pipeline stages.
module spct_prod
    import spct_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [THR_W-1:0] dist_thr,
    input  logic             in_valid,
    output logic             in_ready,
    input  pair_t            in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output prod_t            out_data
);

    logic  diff_valid_reg, prod_valid_reg;
    logic  diff_ready, prod_ready;
    diff_t diff_reg, diff_next;
    prod_t prod_reg, prod_next;
    logic  [2:0][SQ_W-1:0] sq;

    assign prod_ready = !prod_valid_reg || out_ready;
    assign diff_ready = !diff_valid_reg || prod_ready;
    assign in_ready   = diff_ready;
    assign out_valid  = prod_valid_reg;
    assign out_data   = prod_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff_next.d[i] = D_W'($signed(in_data.ca[i])) - D_W'($signed(in_data.cb[i]));
        end
        diff_next.na   = in_data.na;
        diff_next.nb   = in_data.nb;
        diff_next.coef = COEF_W'(dist_thr) * COEF_W'(COEF_SCALE);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod_next.dna[i] = DN_W'($signed(diff_reg.d[i])) * DN_W'($signed(diff_reg.na[i]));
            prod_next.dnb[i] = DN_W'($signed(diff_reg.d[i])) * DN_W'($signed(diff_reg.nb[i]));
            prod_next.nn[i]  = NN_W'($signed(diff_reg.na[i])) * NN_W'($signed(diff_reg.nb[i]));
            sq[i]            = SQ_W'($signed(diff_reg.d[i])) * SQ_W'($signed(diff_reg.d[i]));
            prod_next.dd[i]  = sq[i][DD_W-1:0];
        end
        prod_next.coef2 = COEF2_W'(diff_reg.coef) * COEF2_W'(diff_reg.coef);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            if (diff_ready) diff_valid_reg <= in_valid;
            if (prod_ready) prod_valid_reg <= diff_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (diff_ready && in_valid) diff_reg <= diff_next;
        if (prod_ready && diff_valid_reg) prod_reg <= prod_next;
    end

endmodule

// ===== sv/spct_dot.sv =====
// Dot product sums, absolute values and the angle test, two pipeline stages.
module spct_dot
    import spct_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [ANG_W-1:0] ang_thr,
    input  logic             in_valid,
    output logic             in_ready,
    input  prod_t            in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output geo_t             out_data
);

    logic  sums_valid_reg, geo_valid_reg;
    logic  sums_ready, geo_ready;
    sums_t sums_reg, sums_next;
    geo_t  geo_reg, geo_next;
    logic  [DOT_W-1:0]  neg1, neg2;
    logic  [SIM_W-1:0]  negn;
    logic  [ABS_W-1:0]  abs1, abs2;
    logic  [SABS_W-1:0] sim, sim_min;

    assign geo_ready  = !geo_valid_reg || out_ready;
    assign sums_ready = !sums_valid_reg || geo_ready;
    assign in_ready   = sums_ready;
    assign out_valid  = geo_valid_reg;
    assign out_data   = geo_reg;

    always_comb begin
        sums_next.dot1 = DOT_W'($signed(in_data.dna[0])) + DOT_W'($signed(in_data.dna[1]))
                       + DOT_W'($signed(in_data.dna[2]));
        sums_next.dot2 = DOT_W'($signed(in_data.dnb[0])) + DOT_W'($signed(in_data.dnb[1]))
                       + DOT_W'($signed(in_data.dnb[2]));
        sums_next.dotn = SIM_W'($signed(in_data.nn[0])) + SIM_W'($signed(in_data.nn[1]))
                       + SIM_W'($signed(in_data.nn[2]));
        sums_next.dds  = DDS_W'(in_data.dd[0]) + DDS_W'(in_data.dd[1]) + DDS_W'(in_data.dd[2]);
        sums_next.coef2 = in_data.coef2;
    end

    always_comb begin
        neg1 = -sums_reg.dot1;
        neg2 = -sums_reg.dot2;
        negn = -sums_reg.dotn;
        abs1 = sums_reg.dot1[DOT_W-1] ? neg1[ABS_W-1:0] : sums_reg.dot1[ABS_W-1:0];
        abs2 = sums_reg.dot2[DOT_W-1] ? neg2[ABS_W-1:0] : sums_reg.dot2[ABS_W-1:0];
        sim  = sums_reg.dotn[SIM_W-1] ? negn[SABS_W-1:0] : sums_reg.dotn[SABS_W-1:0];
        // threshold is Q1.14, sim is Q.28
        sim_min = SABS_W'({ang_thr, {ANG_SHIFT{1'b0}}});
        geo_next.perp     = PERP_W'(abs1) + PERP_W'(abs2);
        geo_next.dds      = sums_reg.dds;
        geo_next.coef2    = sums_reg.coef2;
        geo_next.angle_ok = sim > sim_min;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sums_valid_reg <= 1'b0;
            geo_valid_reg  <= 1'b0;
        end else begin
            if (sums_ready) sums_valid_reg <= in_valid;
            if (geo_ready) geo_valid_reg <= sums_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sums_ready && in_valid) sums_reg <= sums_next;
        if (geo_ready && sums_valid_reg) geo_reg <= geo_next;
    end

endmodule

// ===== sv/spct_cmp.sv =====
// Exact squared distance test via partial products, four pipeline stages.
module spct_cmp
    import spct_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  geo_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output logic connected
);

    logic v5_reg, v6_reg, v7_reg, v8_reg;
    logic r5, r6, r7, r8;

    // stage 5: partial products
    logic [2*PH_W-1:0]        hh_reg, hh_next;
    logic [PH_W+PL_W-1:0]     hl_reg, hl_next;
    logic [2*PL_W-1:0]        ll_reg, ll_next;
    logic [2:0][PART_W-1:0]   plo_reg, plo_next, phi_reg, phi_next;
    logic                     ang5_reg;
    logic [PH_W-1:0]          ph;
    logic [PL_W-1:0]          pl;
    logic [DH_W-1:0]          dh;
    logic [DL_W-1:0]          dl;
    logic [2:0][CP_W-1:0]     cs;
    // stage 6: partial sums
    logic [LHS_W-1:0]         lhs6_reg, lhs6_next;
    logic [2:0][GRP_W-1:0]    grp_reg, grp_next;
    logic                     ang6_reg;
    // stage 7: right-hand side
    logic [LHS_W-1:0]         lhs7_reg;
    logic [RHS_W-1:0]         rhs_reg, rhs_next;
    logic                     ang7_reg;
    // stage 8: result
    logic                     conn_reg, conn_next;

    assign r8 = !v8_reg || out_ready;
    assign r7 = !v7_reg || r8;
    assign r6 = !v6_reg || r7;
    assign r5 = !v5_reg || r6;
    assign in_ready  = r5;
    assign out_valid = v8_reg;
    assign connected = conn_reg;

    always_comb begin
        ph = in_data.perp[PERP_W-1:PL_W];
        pl = in_data.perp[PL_W-1:0];
        dh = in_data.dds[DDS_W-1:DL_W];
        dl = in_data.dds[DL_W-1:0];
        hh_next = (2*PH_W)'(ph) * (2*PH_W)'(ph);
        hl_next = (PH_W+PL_W)'(ph) * (PH_W+PL_W)'(pl);
        ll_next = (2*PL_W)'(pl) * (2*PL_W)'(pl);
        for (int k = 0; k < 3; k++) begin
            cs[k]       = in_data.coef2[k*CP_W +: CP_W];
            plo_next[k] = PART_W'(cs[k]) * PART_W'(dl);
            phi_next[k] = PART_W'(cs[k]) * PART_W'(dh);
        end
    end

    always_comb begin
        // perp^2 = ph^2 * 2^34 + 2 * ph * pl * 2^17 + pl^2
        lhs6_next = (LHS_W'(hh_reg) << (2*PL_W)) + (LHS_W'(hl_reg) << (PL_W+1))
                  + LHS_W'(ll_reg);
        for (int k = 0; k < 3; k++) begin
            grp_next[k] = (GRP_W'(phi_reg[k]) << DL_W) + GRP_W'(plo_reg[k]);
        end
    end

    always_comb begin
        rhs_next = (RHS_W'(grp_reg[2]) << (2*CP_W)) + (RHS_W'(grp_reg[1]) << CP_W)
                 + RHS_W'(grp_reg[0]);
        // equal centroids give zero on both sides, so the strict test fails
        conn_next = ang7_reg && (RHS_W'(lhs7_reg) < rhs_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else begin
            if (r5) v5_reg <= in_valid;
            if (r6) v6_reg <= v5_reg;
            if (r7) v7_reg <= v6_reg;
            if (r8) v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (r5 && in_valid) begin
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            plo_reg  <= plo_next;
            phi_reg  <= phi_next;
            ang5_reg <= in_data.angle_ok;
        end
        if (r6 && v5_reg) begin
            lhs6_reg <= lhs6_next;
            grp_reg  <= grp_next;
            ang6_reg <= ang5_reg;
        end
        if (r7 && v6_reg) begin
            lhs7_reg <= lhs6_reg;
            rhs_reg  <= rhs_next;
            ang7_reg <= ang6_reg;
        end
        if (r8 && v7_reg) conn_reg <= conn_next;
    end

endmodule

// ===== sv/surface_patch_connection_test.sv =====
// Top level: configuration registers and the eight-stage connection test pipeline.
//
// Takes one pair of surface patches (centroid and unit normal each) per cycle and returns one
// item per pair: connected is 1 when the perpendicular distance term is below
// 40*distance_threshold*|d| and |na.nb| exceeds angular_threshold. The test is exact, with no
// rounding. Throughput is one pair per clock while m_ready is high; m_valid rises when the
// pair reaches the last of the eight register stages (difference, products, sums, absolute
// values, partial products of the squared test, partial sums, right-hand side, compare), the
// first of which loads at the edge that accepts the pair. Bubbles collapse, so input keeps
// flowing while a result waits on m_ready until all eight stages hold an item.
// Configuration: index 0 distance_threshold (Q4.12), index 1 angular_threshold (Q1.14); other
// indexes are ignored. Write only while no item is in flight.
module surface_patch_connection_test
    import spct_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [CRD_W-1:0] s_first_center_x,
    input  logic signed [CRD_W-1:0] s_first_center_y,
    input  logic signed [CRD_W-1:0] s_first_center_z,
    input  logic signed [CRD_W-1:0] s_first_normal_x,
    input  logic signed [CRD_W-1:0] s_first_normal_y,
    input  logic signed [CRD_W-1:0] s_first_normal_z,
    input  logic signed [CRD_W-1:0] s_second_center_x,
    input  logic signed [CRD_W-1:0] s_second_center_y,
    input  logic signed [CRD_W-1:0] s_second_center_z,
    input  logic signed [CRD_W-1:0] s_second_normal_x,
    input  logic signed [CRD_W-1:0] s_second_normal_y,
    input  logic signed [CRD_W-1:0] s_second_normal_z,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_connected
);

    logic [THR_W-1:0] dist_thr_reg, dist_thr_next;
    logic [ANG_W-1:0] ang_thr_reg, ang_thr_next;
    pair_t pair;
    prod_t prod;
    geo_t  geo;
    logic  prod_valid, prod_ready, geo_valid, geo_ready;

    assign cfg_ready = 1'b1;

    always_comb begin
        dist_thr_next = dist_thr_reg;
        ang_thr_next  = ang_thr_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DIST_THR: dist_thr_next = cfg_data[THR_W-1:0];
                CFG_ANG_THR:  ang_thr_next  = cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_thr_reg <= DIST_THR_RESET;
            ang_thr_reg  <= ANG_THR_RESET;
        end else begin
            dist_thr_reg <= dist_thr_next;
            ang_thr_reg  <= ang_thr_next;
        end
    end

    assign pair.ca = {s_first_center_z, s_first_center_y, s_first_center_x};
    assign pair.na = {s_first_normal_z, s_first_normal_y, s_first_normal_x};
    assign pair.cb = {s_second_center_z, s_second_center_y, s_second_center_x};
    assign pair.nb = {s_second_normal_z, s_second_normal_y, s_second_normal_x};

    spct_prod u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dist_thr  (dist_thr_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (pair),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod)
    );

    spct_dot u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ang_thr   (ang_thr_reg),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod),
        .out_valid (geo_valid),
        .out_ready (geo_ready),
        .out_data  (geo)
    );

    spct_cmp u_cmp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (geo_valid),
        .in_ready  (geo_ready),
        .in_data   (geo),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .connected (m_connected)
    );

endmodule
